>>> rtl/brf_pkg.sv
// shared types and constants of the circular byte fifo
package brf_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP1    = 3'd1,
        CMD_PEEK1   = 3'd2,
        CMD_PEEK_N  = 3'd3,
        CMD_REMOVE_N = 3'd4,
        CMD_POP_N   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

endpackage

>>> rtl/brf_in_if.sv
// command channel of the circular byte fifo
interface brf_in_if;
    logic                       valid;
    logic                       ready;
    logic [brf_pkg::CMD_W-1:0]  cmd;
    logic [brf_pkg::DATA_W-1:0] data_in;
    logic [brf_pkg::CNT_W-1:0]  count;

    modport source (output valid, cmd, data_in, count, input ready);
    modport sink   (input valid, cmd, data_in, count, output ready);
endinterface

>>> rtl/brf_out_if.sv
// result channel of the circular byte fifo
interface brf_out_if #(
    parameter int FILL_W = 9
);
    logic                       valid;
    logic                       ready;
    logic [brf_pkg::DATA_W-1:0] data_out;
    logic [brf_pkg::STAT_W-1:0] status;
    logic [brf_pkg::CNT_W-1:0]  bytes_done;
    logic [FILL_W-1:0]          fill_level;
    logic                       last;

    modport source (output valid, data_out, status, bytes_done, fill_level, last, input ready);
    modport sink   (input valid, data_out, status, bytes_done, fill_level, last, output ready);
endinterface

>>> rtl/byte_ring_fifo_overwrite_top.sv
// top level of the circular byte fifo with overwrite of the oldest byte
// A push goes from idle to emit, with a read pointer step in between when
// the ring is full and the oldest byte is dropped. An unused command or a
// burst that reads nothing goes straight to emit, a remove of N bytes passes
// the skip state once per byte, and a pop or peek passes each byte through
// read, data and emit: every byte goes through one read of the ring port with
// its registered data and through the single pointer incrementer that all
// pointer moves share. A new command is taken only when the sequencer is
// back in idle; a result waiting in the output register does not hold it
// off. The output register holds one result until it is taken.
module byte_ring_fifo_overwrite_top #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_BURST  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brf_in_if.sink     i_in,
    brf_out_if.source  o_out
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CNT_W  = brf_pkg::CNT_W;
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam logic [CNT_W-1:0]  BURST_MAX = CNT_W'(MAX_BURST);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RP,
        S_READ,
        S_DATA,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                     r_state;
    t_state                     r_after;
    logic [PTR_W-1:0]           r_rp;
    logic [PTR_W-1:0]           r_wp;
    logic [PTR_W-1:0]           r_walk;
    logic [FILL_W-1:0]          r_count;
    logic [CNT_W-1:0]           r_left;
    logic                       r_commit;
    logic [brf_pkg::DATA_W-1:0] r_res_data;
    brf_pkg::t_status           r_res_status;
    logic [CNT_W-1:0]           r_res_done;
    logic [FILL_W-1:0]          r_res_fill;
    logic                       r_res_last;
    logic                       r_out_valid;
    logic [brf_pkg::DATA_W-1:0] r_out_data;
    brf_pkg::t_status           r_out_status;
    logic [CNT_W-1:0]           r_out_done;
    logic [FILL_W-1:0]          r_out_fill;
    logic                       r_out_last;

    logic [PTR_W-1:0]           step_in;
    logic [PTR_W-1:0]           step_out;
    logic [brf_pkg::DATA_W-1:0] rd_data;
    logic                       in_xfer;
    logic                       out_free;
    brf_pkg::t_cmd              cmd;
    logic [CNT_W-1:0]           req_sat;
    logic [CNT_W-1:0]           req;
    logic                       short_req;
    logic [CNT_W-1:0]           n_take;
    logic                       is_peek;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign cmd      = brf_pkg::t_cmd'(i_in.cmd);

    // clip the request to the burst limit and to the stored bytes
    always_comb begin
        req_sat = (i_in.count > BURST_MAX) ? BURST_MAX : i_in.count;
        req     = (cmd == brf_pkg::CMD_POP1 || cmd == brf_pkg::CMD_PEEK1)
                  ? CNT_W'(1) : req_sat;
        short_req = CMP_W'(req) > CMP_W'(r_count);
        n_take    = short_req ? CNT_W'(r_count) : req;
        is_peek   = (cmd == brf_pkg::CMD_PEEK1 || cmd == brf_pkg::CMD_PEEK_N);
    end

    always_comb begin
        case (r_state)
            S_PUSH_RP: step_in = r_rp;
            S_READ:    step_in = r_walk;
            S_SKIP:    step_in = r_walk;
            default:   step_in = r_wp;
        endcase
    end

    brf_step #(
        .DEPTH (RING_DEPTH),
        .PTR_W (PTR_W)
    ) u_step (
        .i_ptr  (step_in),
        .o_next (step_out)
    );

    brf_ring #(
        .DEPTH (RING_DEPTH),
        .PTR_W (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && cmd == brf_pkg::CMD_PUSH),
        .i_wr_addr (r_wp),
        .i_wr_data (i_in.data_in),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_walk),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_commit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_data <= '0;
                        r_res_last <= 1'b1;
                        r_after    <= S_IDLE;
                        r_walk     <= r_rp;
                        case (cmd)
                            brf_pkg::CMD_PUSH: begin
                                r_wp       <= step_out;
                                r_commit   <= 1'b0;
                                r_res_done <= CNT_W'(1);
                                if (r_count == FULL_CNT) begin
                                    r_res_status <= brf_pkg::ST_FULL;
                                    r_res_fill   <= r_count;
                                    r_state      <= S_PUSH_RP;
                                end else begin
                                    r_count      <= r_count + FILL_W'(1);
                                    r_res_status <= brf_pkg::ST_OK;
                                    r_res_fill   <= r_count + FILL_W'(1);
                                    r_state      <= S_EMIT;
                                end
                            end
                            brf_pkg::CMD_POP1, brf_pkg::CMD_PEEK1, brf_pkg::CMD_PEEK_N,
                            brf_pkg::CMD_REMOVE_N, brf_pkg::CMD_POP_N: begin
                                r_commit     <= !is_peek;
                                r_left       <= n_take;
                                r_res_done   <= n_take;
                                r_res_status <= short_req ? brf_pkg::ST_SHORT : brf_pkg::ST_OK;
                                if (is_peek) begin
                                    r_res_fill <= r_count;
                                end else begin
                                    r_count    <= r_count - FILL_W'(n_take);
                                    r_res_fill <= r_count - FILL_W'(n_take);
                                end
                                if (n_take == '0) begin
                                    r_state <= S_EMIT;
                                end else if (cmd == brf_pkg::CMD_REMOVE_N) begin
                                    r_state <= S_SKIP;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_commit     <= 1'b0;
                                r_res_done   <= '0;
                                r_res_status <= brf_pkg::ST_OK;
                                r_res_fill   <= r_count;
                                r_state      <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_PUSH_RP: begin
                    r_rp    <= step_out;
                    r_state <= S_EMIT;
                end
                S_SKIP: begin
                    r_walk <= step_out;
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_after <= S_IDLE;
                        r_state <= S_EMIT;
                    end
                end
                S_READ: begin
                    r_walk  <= step_out;
                    r_left  <= r_left - CNT_W'(1);
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_res_data <= rd_data;
                    r_res_last <= (r_left == '0);
                    r_after    <= (r_left == '0) ? S_IDLE : S_READ;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_res_data;
                        r_out_status <= r_res_status;
                        r_out_done   <= r_res_done;
                        r_out_fill   <= r_res_fill;
                        r_out_last   <= r_res_last;
                        r_state      <= r_after;
                        if (r_after == S_IDLE && r_commit) begin
                            r_rp <= r_walk;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.data_out   = r_out_data;
    assign o_out.status     = r_out_status;
    assign o_out.bytes_done = r_out_done;
    assign o_out.fill_level = r_out_fill;
    assign o_out.last       = r_out_last;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("command taken while the previous one is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above ring depth");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == brf_pkg::ST_FULL |-> o_out.fill_level == FULL_CNT)
        else $error("overwrite reported on a ring that is not full");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && r_count == '0 |-> r_rp == r_wp)
        else $error("empty ring with unequal pointers");

endmodule

>>> rtl/brf_ring.sv
// byte ring memory, one write port and one registered read port
module brf_ring #(
    parameter int DEPTH = 256,
    parameter int PTR_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [PTR_W-1:0]           i_wr_addr,
    input  logic [brf_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [PTR_W-1:0]           i_rd_addr,
    output logic [brf_pkg::DATA_W-1:0] o_rd_data
);

    logic [brf_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [brf_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/brf_step.sv
// shared pointer incrementer, wraps at the ring depth
module brf_step #(
    parameter int DEPTH = 256,
    parameter int PTR_W = 8
) (
    input  logic [PTR_W-1:0] i_ptr,
    output logic [PTR_W-1:0] o_next
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    assign o_next = (i_ptr == LAST_PTR) ? '0 : i_ptr + PTR_W'(1);

endmodule
